[hdl/bsle_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bsle_pkg: shared types and constants of the bounded sorted list engine
// Holds the list geometry, operation codes and the command and status
// records that join the controller and the datapath.
// ----------------------------------------------------------------------------
package bsle_pkg;

  // List geometry.
  localparam int DEPTH        = 64;
  localparam int PAYLOAD_BITS = 64;

  // Port field widths.
  localparam int KIND_W    = 3;
  localparam int KEY_W     = 32;
  localparam int IN_PAY_W  = 64;
  localparam int POS_W     = 6;

  // Derived widths.
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int WORD_W = KEY_W + PAYLOAD_BITS;

  // Operation codes carried by a request.
  typedef enum logic [KIND_W-1:0] {
    K_APPEND    = 3'd0,
    K_PREPEND   = 3'd1,
    K_SORTED    = 3'd2,
    K_REM_LAST  = 3'd3,
    K_REM_FIRST = 3'd4,
    K_REM_KEY   = 3'd5,
    K_RD_INDEX  = 3'd6,
    K_RD_KEY    = 3'd7
  } kind_t;

  // Next value of the walk pointer. The RAM read address follows it.
  typedef enum logic [2:0] {
    PTR_HOLD = 3'd0,
    PTR_ZERO = 3'd1,
    PTR_POS  = 3'd2,
    PTR_INC  = 3'd3,
    PTR_DEC  = 3'd4,
    PTR_TOP  = 3'd5,
    PTR_AT1  = 3'd6
  } ptr_op_t;

  // Insert or removal position update.
  typedef enum logic [1:0] {
    AT_HOLD = 2'd0,
    AT_ZERO = 2'd1,
    AT_CNT  = 2'd2,
    AT_PTR  = 2'd3
  } at_op_t;

  // RAM write selection.
  typedef enum logic [1:0] {
    WR_NONE = 2'd0,
    WR_UP   = 2'd1,
    WR_DN   = 2'd2,
    WR_NEW  = 2'd3
  } wr_sel_t;

  // Entry count update.
  typedef enum logic [1:0] {
    CNT_HOLD = 2'd0,
    CNT_INC  = 2'd1,
    CNT_DEC  = 2'd2
  } cnt_op_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    accept;
    ptr_op_t ptr_op;
    at_op_t  at_op;
    wr_sel_t wr_sel;
    cnt_op_t cnt_op;
    logic    srch_order;
    logic    res_ok;
    logic    res_cap;
    logic    load_out;
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic empty;
    logic pos_ok;
    logic srch_end;
    logic srch_hit;
    logic at_is_cnt;
    logic at1_ge_cnt;
    logic ptr_is_at;
    logic ptr1_is_cnt;
    logic out_busy;
  } dp_status_t;

endpackage
`default_nettype wire

[hdl/bsle_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bsle_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module bsle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

[hdl/bsle_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bsle_ctrl: sequencer of the bounded sorted list engine
// Accepts a request, walks the list through search and shift states and
// hands the result to the output register.
// ----------------------------------------------------------------------------
module bsle_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [bsle_pkg::KIND_W-1:0] in_kind,
  input  bsle_pkg::dp_status_t        status,
  output bsle_pkg::ctl_cmd_t          cmd
);
  import bsle_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_SEARCH = 10'b0000000010,
    S_RDIDX  = 10'b0000000100,
    S_SHUP0  = 10'b0000001000,
    S_SHUP   = 10'b0000010000,
    S_WRNEW  = 10'b0000100000,
    S_SHDN0  = 10'b0001000000,
    S_SHDN   = 10'b0010000000,
    S_DEC    = 10'b0100000000,
    S_FIN    = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;
  kind_t  kind_r, kind_nxt;
  kind_t  in_op;

  assign in_op    = kind_t'(in_kind);
  assign in_stall = (state_r != S_IDLE);

  // State and operation registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      kind_r  <= K_APPEND;
    end else begin
      state_r <= state_nxt;
      kind_r  <= kind_nxt;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_nxt      = state_r;
    kind_nxt       = kind_r;
    cmd            = '0;
    cmd.ptr_op     = PTR_HOLD;
    cmd.at_op      = AT_HOLD;
    cmd.wr_sel     = WR_NONE;
    cmd.cnt_op     = CNT_HOLD;
    cmd.srch_order = (kind_r == K_SORTED);
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          kind_nxt   = in_op;
          unique case (in_op)
            K_APPEND: begin
              cmd.at_op = AT_CNT;
              state_nxt = status.full ? S_FIN : S_WRNEW;
            end
            K_PREPEND: begin
              cmd.at_op = AT_ZERO;
              state_nxt = status.full ? S_FIN : S_SHUP0;
            end
            K_SORTED: begin
              cmd.ptr_op = PTR_ZERO;
              state_nxt  = status.full ? S_FIN : S_SEARCH;
            end
            K_REM_LAST: begin
              state_nxt = status.empty ? S_FIN : S_DEC;
            end
            K_REM_FIRST: begin
              cmd.at_op = AT_ZERO;
              state_nxt = status.empty ? S_FIN : S_SHDN0;
            end
            K_REM_KEY, K_RD_KEY: begin
              cmd.ptr_op = PTR_ZERO;
              state_nxt  = S_SEARCH;
            end
            K_RD_INDEX: begin
              cmd.ptr_op = PTR_POS;
              state_nxt  = status.pos_ok ? S_RDIDX : S_FIN;
            end
            default: begin
              state_nxt = S_FIN;
            end
          endcase
        end
      end
      // One entry compared per cycle; the end of the list wins over a hit.
      S_SEARCH: begin
        if (status.srch_end) begin
          cmd.at_op = AT_PTR;
          state_nxt = (kind_r == K_SORTED) ? S_SHUP0 : S_FIN;
        end else if (status.srch_hit) begin
          cmd.at_op = AT_PTR;
          priority if (kind_r == K_SORTED) begin
            state_nxt = S_SHUP0;
          end else if (kind_r == K_REM_KEY) begin
            state_nxt = S_SHDN0;
          end else begin
            cmd.res_cap = 1'b1;
            state_nxt   = S_FIN;
          end
        end else begin
          cmd.ptr_op = PTR_INC;
        end
      end
      S_RDIDX: begin
        cmd.res_cap = 1'b1;
        state_nxt   = S_FIN;
      end
      // Open a gap at the insert position, moving entries up from the top.
      S_SHUP0: begin
        if (status.at_is_cnt) begin
          state_nxt = S_WRNEW;
        end else begin
          cmd.ptr_op = PTR_TOP;
          state_nxt  = S_SHUP;
        end
      end
      S_SHUP: begin
        cmd.wr_sel = WR_UP;
        if (status.ptr_is_at) begin
          state_nxt = S_WRNEW;
        end else begin
          cmd.ptr_op = PTR_DEC;
        end
      end
      S_WRNEW: begin
        cmd.wr_sel = WR_NEW;
        cmd.cnt_op = CNT_INC;
        cmd.res_ok = 1'b1;
        state_nxt  = S_FIN;
      end
      // Close the gap at the removal position, moving entries down.
      S_SHDN0: begin
        if (status.at1_ge_cnt) begin
          state_nxt = S_DEC;
        end else begin
          cmd.ptr_op = PTR_AT1;
          state_nxt  = S_SHDN;
        end
      end
      S_SHDN: begin
        cmd.wr_sel = WR_DN;
        if (status.ptr1_is_cnt) begin
          state_nxt = S_DEC;
        end else begin
          cmd.ptr_op = PTR_INC;
        end
      end
      S_DEC: begin
        cmd.cnt_op = CNT_DEC;
        cmd.res_ok = 1'b1;
        state_nxt  = S_FIN;
      end
      // Wait for room in the output register.
      S_FIN: begin
        if (!status.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

`ifndef SYNTH
  // A result never overwrites one that is still held by a stalled receiver.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> !status.out_busy)
    else $error("result loaded while output register is stalled");

  // An accepted request always starts work.
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && in_valid) |=> (state_r != S_IDLE))
    else $error("accepted request did not leave idle");
`endif

endmodule
`default_nettype wire

[hdl/bsle_dpath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bsle_dpath: storage and walk datapath of the bounded sorted list engine
// Holds the entry RAM, count, walk pointer, request fields, result and the
// output register.
// ----------------------------------------------------------------------------
module bsle_dpath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  bsle_pkg::ctl_cmd_t            cmd,
  output bsle_pkg::dp_status_t          status,
  input  logic signed [bsle_pkg::KEY_W-1:0]    in_entry_key,
  input  logic [bsle_pkg::IN_PAY_W-1:0] in_entry_payload,
  input  logic [bsle_pkg::POS_W-1:0]    in_position,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_ok,
  output logic signed [bsle_pkg::KEY_W-1:0]    out_key,
  output logic [bsle_pkg::IN_PAY_W-1:0] out_payload,
  output logic [bsle_pkg::CNT_W-1:0]    out_entry_count,
  output logic                          out_is_full,
  output logic                          out_is_empty
);
  import bsle_pkg::*;

  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [CNT_W-1:0]        ptr_r, ptr_nxt;
  logic [CNT_W-1:0]        at_r, at_nxt;
  logic [KEY_W-1:0]        key_r;
  logic [PAYLOAD_BITS-1:0] pay_r;
  logic                    res_ok_r;
  logic [KEY_W-1:0]        res_key_r;
  logic [PAYLOAD_BITS-1:0] res_pay_r;
  logic                    out_valid_r;
  logic                    out_ok_r;
  logic [KEY_W-1:0]        out_key_r;
  logic [PAYLOAD_BITS-1:0] out_pay_r;
  logic [CNT_W-1:0]        out_cnt_r;

  logic                    we;
  logic [CNT_W-1:0]        waddr_w;
  logic [WORD_W-1:0]       wdata;
  logic [WORD_W-1:0]       rdata;
  logic [KEY_W-1:0]        rd_key;
  logic [PAYLOAD_BITS-1:0] rd_pay;

  assign rd_key = rdata[WORD_W-1 -: KEY_W];
  assign rd_pay = rdata[PAYLOAD_BITS-1:0];

  // Walk pointer; the RAM reads at its next value so data lines up with it.
  always_comb begin
    unique case (cmd.ptr_op)
      PTR_HOLD: ptr_nxt = ptr_r;
      PTR_ZERO: ptr_nxt = '0;
      PTR_POS:  ptr_nxt = CNT_W'(in_position);
      PTR_INC:  ptr_nxt = ptr_r + 1'b1;
      PTR_DEC:  ptr_nxt = ptr_r - 1'b1;
      PTR_TOP:  ptr_nxt = cnt_r - 1'b1;
      PTR_AT1:  ptr_nxt = at_r + 1'b1;
      default:  ptr_nxt = ptr_r;
    endcase
  end

  // Position register for inserts and removals.
  always_comb begin
    unique case (cmd.at_op)
      AT_HOLD: at_nxt = at_r;
      AT_ZERO: at_nxt = '0;
      AT_CNT:  at_nxt = cnt_r;
      AT_PTR:  at_nxt = ptr_r;
      default: at_nxt = at_r;
    endcase
  end

  // Entry count.
  always_comb begin
    unique case (cmd.cnt_op)
      CNT_HOLD: cnt_nxt = cnt_r;
      CNT_INC:  cnt_nxt = cnt_r + 1'b1;
      CNT_DEC:  cnt_nxt = cnt_r - 1'b1;
      default:  cnt_nxt = cnt_r;
    endcase
  end

  // RAM write: shift up, shift down, or store the new entry.
  always_comb begin
    we      = 1'b1;
    waddr_w = at_r;
    wdata   = rdata;
    unique case (cmd.wr_sel)
      WR_NONE: we = 1'b0;
      WR_UP:   waddr_w = ptr_r + 1'b1;
      WR_DN:   waddr_w = ptr_r - 1'b1;
      WR_NEW:  wdata = {key_r, pay_r};
      default: we = 1'b0;
    endcase
  end

  bsle_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr_w[ADDR_W-1:0]),
    .wdata (wdata),
    .raddr (ptr_nxt[ADDR_W-1:0]),
    .rdata (rdata)
  );

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      ptr_r       <= '0;
      at_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      ptr_r <= ptr_nxt;
      at_r  <= at_nxt;
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Request fields, result and output register.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      key_r     <= in_entry_key;
      pay_r     <= in_entry_payload[PAYLOAD_BITS-1:0];
      res_ok_r  <= 1'b0;
      res_key_r <= '0;
      res_pay_r <= '0;
    end else if (cmd.res_cap) begin
      res_ok_r  <= 1'b1;
      res_key_r <= rd_key;
      res_pay_r <= rd_pay;
    end else if (cmd.res_ok) begin
      res_ok_r <= 1'b1;
    end
    if (cmd.load_out) begin
      out_ok_r  <= res_ok_r;
      out_key_r <= res_key_r;
      out_pay_r <= res_pay_r;
      out_cnt_r <= cnt_r;
    end
  end

  // Status toward the controller.
  always_comb begin
    status.full        = (cnt_r == CNT_W'(DEPTH));
    status.empty       = (cnt_r == '0);
    status.pos_ok      = (CMP_W'(in_position) < CMP_W'(cnt_r));
    status.srch_end    = (ptr_r == cnt_r);
    status.srch_hit    = cmd.srch_order ? !($signed(rd_key) < $signed(key_r))
                                        : (rd_key == key_r);
    status.at_is_cnt   = (at_r == cnt_r);
    status.at1_ge_cnt  = ((at_r + 1'b1) >= cnt_r);
    status.ptr_is_at   = (ptr_r == at_r);
    status.ptr1_is_cnt = ((ptr_r + 1'b1) == cnt_r);
    status.out_busy    = out_valid_r && out_stall;
  end

  assign out_valid       = out_valid_r;
  assign out_ok          = out_ok_r;
  assign out_key         = out_key_r;
  assign out_payload     = IN_PAY_W'(out_pay_r);
  assign out_entry_count = out_cnt_r;
  assign out_is_full     = (out_cnt_r == CNT_W'(DEPTH));
  assign out_is_empty    = (out_cnt_r == '0);

`ifndef SYNTH
  // Every RAM write lands inside the list capacity.
  a_waddr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    we |-> (waddr_w < CNT_W'(DEPTH)))
    else $error("RAM write beyond capacity");

  // A new entry is only stored while there is room for it.
  a_no_insert_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.wr_sel == WR_NEW) |-> !status.full)
    else $error("insert into a full list");

  // The count moves only on an explicit command.
  a_cnt_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.cnt_op == CNT_HOLD) |=> $stable(cnt_r))
    else $error("entry count changed without command");
`endif

endmodule
`default_nettype wire

[hdl/bounded_sorted_list_engine_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bounded_sorted_list_engine_top: bounded ordered list of keyed entries
// Append, prepend, sorted insert, remove last, remove first, remove by key,
// read by position and read by key on a list held in one RAM.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake           Fields
//   in_      request    in_valid/in_stall   kind, entry_key, entry_payload,
//                                           position
//   out_     result     out_valid/out_stall ok, key, payload, entry_count,
//                                           is_full, is_empty
//
// Refused requests, append, remove last and read by position need no walk;
// the rest walk the list: the entry RAM has one read and one write port, so
// the walk moves or compares one entry per cycle. Reset clears the count,
// the walk pointer, the position register and the output valid flag; the
// entry RAM needs no clearing pass. in_stall is high from acceptance until
// the result reaches the output register, which holds it while out_stall is
// high; the next request is taken while a result still waits there.
//
module bounded_sorted_list_engine_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [bsle_pkg::KIND_W-1:0]   in_kind,
  input  logic signed [bsle_pkg::KEY_W-1:0]    in_entry_key,
  input  logic [bsle_pkg::IN_PAY_W-1:0] in_entry_payload,
  input  logic [bsle_pkg::POS_W-1:0]    in_position,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_ok,
  output logic signed [bsle_pkg::KEY_W-1:0]    out_key,
  output logic [bsle_pkg::IN_PAY_W-1:0] out_payload,
  output logic [bsle_pkg::CNT_W-1:0]    out_entry_count,
  output logic                          out_is_full,
  output logic                          out_is_empty
);
  import bsle_pkg::*;

  ctl_cmd_t   cmd;
  dp_status_t status;

  // Sequencer.
  bsle_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_kind  (in_kind),
    .status   (status),
    .cmd      (cmd)
  );

  // Storage, walk logic and output register.
  bsle_dpath u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .in_entry_key     (in_entry_key),
    .in_entry_payload (in_entry_payload),
    .in_position      (in_position),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_ok           (out_ok),
    .out_key          (out_key),
    .out_payload      (out_payload),
    .out_entry_count  (out_entry_count),
    .out_is_full      (out_is_full),
    .out_is_empty     (out_is_empty)
  );

endmodule
`default_nettype wire

[tb/bounded_sorted_list_engine_top_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_sorted_list_engine_top_test: self-checking bench for the list engine
// Drives list requests through the valid/stall request channel. Each accepted
// request is applied to a behavioral copy of the list, and every result taken
// from the output channel is compared with the oldest predicted result. Random
// phases swing the list between empty and full so that refusals at both ends,
// key searches, shifts and equal-key placement are all exercised, with random
// gaps on the request side and random stalls on the result side.
// ----------------------------------------------------------------------------
module bounded_sorted_list_engine_top_test;
  import bsle_pkg::*;

  localparam logic [63:0] PAY_MASK = {64{1'b1}} >> (64 - PAYLOAD_BITS);
  localparam int RANDOM_REQUESTS = 800;
  localparam int QUIET_TAIL      = 120;
  localparam int PHASE_LEN       = 40;
  localparam int DRAIN_CYCLES    = 120;

  typedef struct {
    kind_t              op;
    logic signed [31:0] key;
    logic [63:0]        payload;
    logic [POS_W-1:0]   position;
  } list_req_t;

  typedef struct {
    logic               ok;
    logic signed [31:0] key;
    logic [63:0]        payload;
    logic [CNT_W-1:0]   count;
    logic               full;
    logic               empty;
  } list_result_t;

  typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIXED} phase_mode_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [KIND_W-1:0]        in_kind = '0;
  logic signed [KEY_W-1:0]  in_entry_key = '0;
  logic [IN_PAY_W-1:0]      in_entry_payload = '0;
  logic [POS_W-1:0]         in_position = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic                     out_ok;
  logic signed [KEY_W-1:0]  out_key;
  logic [IN_PAY_W-1:0]      out_payload;
  logic [CNT_W-1:0]         out_entry_count;
  logic                     out_is_full;
  logic                     out_is_empty;

  // Behavioral copy of the list.
  logic signed [31:0] list_keys [DEPTH];
  logic [63:0]        list_payloads [DEPTH];
  int                 held = 0;

  list_req_t    pending_requests [$];
  list_req_t    in_flight;
  list_result_t expected_results [$];
  int           mismatches = 0;
  int           idle_pct = 0;
  int           send_gap = 0;
  int           stall_left = 0;

  bounded_sorted_list_engine_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_kind          (in_kind),
    .in_entry_key     (in_entry_key),
    .in_entry_payload (in_entry_payload),
    .in_position      (in_position),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_ok           (out_ok),
    .out_key          (out_key),
    .out_payload      (out_payload),
    .out_entry_count  (out_entry_count),
    .out_is_full      (out_is_full),
    .out_is_empty     (out_is_empty)
  );

  // 50 MHz clock.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Apply one accepted request to the list copy and queue the result it gives.
  task automatic apply_list_op(input list_req_t r);
    list_result_t res;
    int at;
    int i;
    res.ok      = 1'b0;
    res.key     = '0;
    res.payload = '0;
    case (r.op)
      K_APPEND, K_PREPEND, K_SORTED: begin
        if (held < DEPTH) begin
          if (r.op == K_APPEND) begin
            at = held;
          end else if (r.op == K_PREPEND) begin
            at = 0;
          end else begin
            // The new entry goes ahead of the first key that is not smaller.
            at = 0;
            while (at < held && list_keys[at] < r.key) at++;
          end
          for (i = held; i > at; i--) begin
            list_keys[i]     = list_keys[i-1];
            list_payloads[i] = list_payloads[i-1];
          end
          list_keys[at]     = r.key;
          list_payloads[at] = r.payload & PAY_MASK;
          held++;
          res.ok = 1'b1;
        end
      end
      K_REM_LAST: begin
        if (held > 0) begin
          held--;
          res.ok = 1'b1;
        end
      end
      K_REM_FIRST, K_REM_KEY: begin
        at = 0;
        if (r.op == K_REM_KEY) begin
          while (at < held && list_keys[at] != r.key) at++;
        end
        if (at < held) begin
          for (i = at; i + 1 < held; i++) begin
            list_keys[i]     = list_keys[i+1];
            list_payloads[i] = list_payloads[i+1];
          end
          held--;
          res.ok = 1'b1;
        end
      end
      K_RD_INDEX: begin
        if (int'(r.position) < held) begin
          res.ok      = 1'b1;
          res.key     = list_keys[r.position];
          res.payload = list_payloads[r.position];
        end
      end
      default: begin
        at = 0;
        while (at < held && list_keys[at] != r.key) at++;
        if (at < held) begin
          res.ok      = 1'b1;
          res.key     = list_keys[at];
          res.payload = list_payloads[at];
        end
      end
    endcase
    res.count = held[CNT_W-1:0];
    res.full  = (held == DEPTH);
    res.empty = (held == 0);
    expected_results.push_back(res);
  endtask

  task automatic queue_request(input kind_t op, input logic signed [31:0] key,
                               input logic [63:0] payload, input int position);
    list_req_t r;
    r.op       = op;
    r.key      = key;
    r.payload  = payload;
    r.position = position[POS_W-1:0];
    pending_requests.push_back(r);
  endtask

  // Keys come mostly from a narrow range so that searches hit and equal keys
  // meet in sorted inserts.
  function automatic logic signed [31:0] pick_key();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) return $signed($urandom_range(0, 15)) - 8;
    if (sel == 6) begin
      case ($urandom_range(0, 3))
        0: return 32'sh8000_0000;
        1: return 32'sh7fff_ffff;
        2: return 32'sh0;
        default: return -32'sd1;
      endcase
    end
    return $signed($urandom());
  endfunction

  task automatic queue_random(input phase_mode_t mode);
    kind_t op;
    logic signed [31:0] key;
    int roll;
    int position;
    int ins_cut;
    int rem_cut;
    roll = $urandom_range(0, 99);
    case (mode)
      MODE_FILL:  begin ins_cut = 80; rem_cut = 90; end
      MODE_DRAIN: begin ins_cut = 10; rem_cut = 90; end
      default:    begin ins_cut = 35; rem_cut = 60; end
    endcase
    if (roll < ins_cut) begin
      op = kind_t'($urandom_range(K_APPEND, K_SORTED));
    end else if (roll < rem_cut) begin
      op = kind_t'($urandom_range(K_REM_LAST, K_REM_KEY));
    end else begin
      op = kind_t'($urandom_range(K_RD_INDEX, K_RD_KEY));
    end
    if ((op == K_REM_KEY || op == K_RD_KEY) && held > 0 && $urandom_range(0, 9) < 6) begin
      key = list_keys[$urandom_range(0, held - 1)];
    end else begin
      key = pick_key();
    end
    if (held > 0 && $urandom_range(0, 9) < 7) begin
      position = $urandom_range(0, held - 1);
    end else begin
      position = $urandom_range(0, 63);
    end
    queue_request(op, key, {$urandom(), $urandom()}, position);
  endtask

  // Request driver: predicts on acceptance, then presents the next request.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        apply_list_op(in_flight);
        if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
          send_gap = $urandom_range(1, 16);
        end
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_requests.size() > 0) begin
          in_flight = pending_requests.pop_front();
          in_kind          <= in_flight.op;
          in_entry_key     <= in_flight.key;
          in_entry_payload <= in_flight.payload;
          in_position      <= in_flight.position;
          in_valid         <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random stall bursts.
  always @(posedge clk) begin
    list_result_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: result with no request pending: ok=%0b key=%0d count=%0d",
                     $realtime, out_ok, out_key, out_entry_count);
          end
        end else begin
          want = expected_results.pop_front();
          if (out_ok !== want.ok || out_key !== want.key ||
              out_payload !== want.payload || out_entry_count !== want.count ||
              out_is_full !== want.full || out_is_empty !== want.empty) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: result mismatch: expected ok=%0b key=%0d payload=%h count=%0d full=%0b empty=%0b",
                       $realtime, want.ok, want.key, want.payload, want.count,
                       want.full, want.empty);
              $display("%0t:                   actual ok=%0b key=%0d payload=%h count=%0d full=%0b empty=%0b",
                       $realtime, out_ok, out_key, out_payload, out_entry_count,
                       out_is_full, out_is_empty);
            end
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct / 2) begin
        stall_left = $urandom_range(0, 15);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Stimulus: reset, directed requests, then phases that sweep the list.
  initial begin
    phase_mode_t trend;
    phase_mode_t mode;
    int issued;
    int n;
    trend  = MODE_FILL;
    issued = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Requests against an empty list are all refused or miss.
    queue_request(K_REM_LAST, 0, 64'h0, 0);
    queue_request(K_REM_FIRST, 0, 64'h0, 0);
    queue_request(K_REM_KEY, 0, 64'h0, 0);
    queue_request(K_RD_INDEX, 0, 64'h0, 0);
    queue_request(K_RD_KEY, 0, 64'h0, 0);
    // Sorted inserts at the key extremes; the second zero key lands ahead of
    // the first.
    queue_request(K_SORTED, 0, 64'hffff_ffff_ffff_ffff, 0);
    queue_request(K_SORTED, 32'sh7fff_ffff, 64'h5555_5555_5555_5555, 0);
    queue_request(K_SORTED, 32'sh8000_0000, 64'haaaa_aaaa_aaaa_aaaa, 0);
    queue_request(K_SORTED, 0, 64'h0123_4567_89ab_cdef, 0);
    queue_request(K_APPEND, -1, 64'h8000_0000_0000_0001, 0);
    queue_request(K_PREPEND, 5, 64'h0, 0);
    queue_request(K_RD_INDEX, 0, 64'h0, 0);
    queue_request(K_RD_INDEX, 2, 64'h0, 0);
    queue_request(K_RD_INDEX, 63, 64'h0, 0);
    queue_request(K_RD_INDEX, 6, 64'h0, 5);
    queue_request(K_RD_KEY, 0, 64'h0, 0);
    queue_request(K_REM_KEY, 0, 64'h0, 0);
    queue_request(K_RD_KEY, 0, 64'h0, 0);
    queue_request(K_RD_KEY, 1234, 64'h0, 0);
    queue_request(K_REM_KEY, 1234, 64'h0, 0);
    queue_request(K_REM_FIRST, 0, 64'h0, 0);
    queue_request(K_REM_LAST, 0, 64'h0, 0);
    queue_request(K_RD_INDEX, 0, 64'h0, 1);

    // Random phases; the trend flips at full and at empty so both refusal
    // cases recur, and the tail runs without gaps or stalls.
    while (issued < RANDOM_REQUESTS) begin
      while (pending_requests.size() != 0) @(posedge clk);
      if (held == DEPTH) trend = MODE_DRAIN;
      if (held == 0) trend = MODE_FILL;
      mode = ($urandom_range(0, 9) < 7) ? trend : MODE_MIXED;
      if (issued >= RANDOM_REQUESTS - QUIET_TAIL) begin
        idle_pct = 0;
      end else begin
        case ($urandom_range(0, 2))
          0: idle_pct = 0;
          1: idle_pct = 10;
          default: idle_pct = 35;
        endcase
      end
      for (n = 0; n < PHASE_LEN; n++) queue_random(mode);
      issued += PHASE_LEN;
    end

    while (pending_requests.size() > 0 || in_valid || expected_results.size() > 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("bounded_sorted_list_engine_top_test: clean");
    end else begin
      $display("bounded_sorted_list_engine_top_test: errors");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #(20_000_000);
    $display("bounded_sorted_list_engine_top_test: errors");
    $finish;
  end

endmodule
